FILE: sv/text_console_char_engine_macros.svh
// Assertion macros for the text console character engine.
// Used by text_console_char_engine.sv; relies on clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TCCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcce_pkg.sv
// Package for the text console character engine: geometry, widths,
// character codes and the sequencer state type. No dependencies.
package tcce_pkg;

  localparam int unsigned COLS      = 80;
  localparam int unsigned ROWS      = 25;
  localparam int unsigned TAB_WIDTH = 4;
  localparam int unsigned NCELLS    = ROWS * COLS;
  localparam int unsigned LAST_POS  = (ROWS - 1) * COLS;

  localparam int unsigned ADDR_W = $clog2(NCELLS);
  localparam int unsigned CNT_W  = $clog2(NCELLS + 1);
  localparam int unsigned TAB_W  = $clog2(TAB_WIDTH + 1);
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TAB,
    ST_BS_STEP,
    ST_BS_CHECK,
    ST_SCROLL_COPY,
    ST_SCROLL_FILL
  } state_e;

endpackage

FILE: sv/text_console_char_engine.sv
// Text console character engine: screen store, cursor and sequencer.
// Depends on tcce_pkg and text_console_char_engine_macros.svh.
//
// A command is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done_o high and cannot be
// held off. A printable character or a newline without scroll is handled
// directly from idle, a cell read passes through ST_READ, a tab writes one
// space at a time in ST_TAB, and backspace passes through ST_BS_STEP and
// ST_BS_CHECK per erased cell. A scroll copies the store through its single
// read and write port one cell a cycle, then fills the last row with spaces.
// After reset a clearing pass fills the store with spaces while busy is held high.
`include "text_console_char_engine_macros.svh"

module text_console_char_engine import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              action_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [IDX_W-1:0]  cell_index_i,
  output logic              done_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [CHAR_W-1:0] cell_char_o
);

  logic [CHAR_W-1:0] mem [NCELLS];

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TAB_W-1:0]  tab_n_q, tab_n_d;
  logic              rd_oor_q, rd_oor_d;
  logic              done_q, done_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [CHAR_W-1:0] out_cell_q, out_cell_d;
  logic [CHAR_W-1:0] rdata_q;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CHAR_W-1:0] mem_wd;
  logic [ADDR_W-1:0] rd_addr;

  // shared cursor advance unit
  logic [TAB_W-1:0]  adv_n;
  logic [COL_W:0]    col_sum;
  logic              adv_wrap, adv_last, adv_scroll;
  logic [ROW_W-1:0]  adv_row;
  logic [COL_W-1:0]  adv_col;
  logic [ADDR_W-1:0] adv_pos;
  logic [ADDR_W-1:0] next_row_pos;
  logic [CNT_W:0]    tab_addr;
  logic              tab_last, rd_blank;

  assign busy = (state_q != ST_IDLE);

  assign adv_n        = (state_q == ST_TAB) ? tab_n_q : TAB_W'(1);
  assign col_sum      = {1'b0, col_q} + (COL_W + 1)'(adv_n);
  assign adv_wrap     = col_sum >= (COL_W + 1)'(COLS);
  assign adv_last     = row_q == ROW_W'(ROWS - 1);
  assign adv_scroll   = adv_wrap && adv_last;
  assign next_row_pos = pos_q - ADDR_W'(col_q) + ADDR_W'(COLS);
  assign tab_addr     = (CNT_W + 1)'(pos_q) + (CNT_W + 1)'(cnt_q);
  assign tab_last     = cnt_q == CNT_W'(tab_n_q - TAB_W'(1));
  assign rd_blank     = (rdata_q == CH_BLANK) || (rdata_q == CH_NUL);

  always_comb begin
    if (!adv_wrap) begin
      adv_row = row_q;
      adv_col = col_sum[COL_W-1:0];
      adv_pos = pos_q + ADDR_W'(adv_n);
    end else if (!adv_last) begin
      adv_row = row_q + ROW_W'(1);
      adv_col = '0;
      adv_pos = next_row_pos;
    end else begin
      adv_row = ROW_W'(ROWS - 1);
      adv_col = '0;
      adv_pos = ADDR_W'(LAST_POS);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(NCELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACT_READ) begin
            state_d = ST_READ;
          end else begin
            case (char_code_i)
              CH_BS:  if (pos_q != '0) state_d = ST_BS_STEP;
              CH_TAB: state_d = ST_TAB;
              CH_NL:  if (adv_last) state_d = ST_SCROLL_COPY;
              default: if (adv_scroll) state_d = ST_SCROLL_COPY;
            endcase
          end
        end
      end
      ST_READ:     state_d = ST_IDLE;
      ST_TAB: begin
        if (tab_last) state_d = adv_scroll ? ST_SCROLL_COPY : ST_IDLE;
      end
      ST_BS_STEP:  state_d = ST_BS_CHECK;
      ST_BS_CHECK: state_d = (pos_q != '0 && rd_blank) ? ST_BS_STEP : ST_IDLE;
      ST_SCROLL_COPY: begin
        if (cnt_q == CNT_W'(NCELLS)) state_d = ST_SCROLL_FILL;
      end
      ST_SCROLL_FILL: begin
        if (cnt_q == CNT_W'(NCELLS - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pos_d      = pos_q;
    row_d      = row_q;
    col_d      = col_q;
    cnt_d      = cnt_q;
    tab_n_d    = tab_n_q;
    rd_oor_d   = rd_oor_q;
    done_d     = 1'b0;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_cell_d = out_cell_q;
    mem_we     = 1'b0;
    mem_wa     = pos_q;
    mem_wd     = CH_BLANK;
    rd_addr    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[ADDR_W-1:0];
        cnt_d  = (cnt_q == CNT_W'(NCELLS - 1)) ? '0 : cnt_q + CNT_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACT_READ) begin
            rd_oor_d = cell_index_i >= IDX_W'(NCELLS);
            rd_addr  = rd_oor_d ? '0 : cell_index_i[ADDR_W-1:0];
          end else begin
            case (char_code_i)
              CH_BS: begin
                if (pos_q == '0) begin
                  done_d     = 1'b1;
                  out_row_d  = row_q;
                  out_col_d  = col_q;
                  out_cell_d = '0;
                end
              end
              CH_TAB: begin
                tab_n_d = TAB_W'(TAB_WIDTH - (pos_q % TAB_WIDTH));
                cnt_d   = '0;
              end
              CH_NL: begin
                col_d = '0;
                if (!adv_last) begin
                  row_d      = row_q + ROW_W'(1);
                  pos_d      = next_row_pos;
                  done_d     = 1'b1;
                  out_row_d  = row_q + ROW_W'(1);
                  out_col_d  = '0;
                  out_cell_d = '0;
                end else begin
                  pos_d = ADDR_W'(LAST_POS);
                  cnt_d = CNT_W'(COLS);
                end
              end
              default: begin
                mem_we = 1'b1;
                mem_wa = pos_q;
                mem_wd = char_code_i;
                row_d  = adv_row;
                col_d  = adv_col;
                pos_d  = adv_pos;
                if (adv_scroll) begin
                  cnt_d = CNT_W'(COLS);
                end else begin
                  done_d     = 1'b1;
                  out_row_d  = adv_row;
                  out_col_d  = adv_col;
                  out_cell_d = '0;
                end
              end
            endcase
          end
        end
      end
      ST_READ: begin
        done_d     = 1'b1;
        out_row_d  = row_q;
        out_col_d  = col_q;
        out_cell_d = rd_oor_q ? '0 : rdata_q;
      end
      ST_TAB: begin
        mem_we = tab_addr < (CNT_W + 1)'(NCELLS);
        mem_wa = tab_addr[ADDR_W-1:0];
        cnt_d  = cnt_q + CNT_W'(1);
        if (tab_last) begin
          row_d = adv_row;
          col_d = adv_col;
          pos_d = adv_pos;
          if (adv_scroll) begin
            cnt_d = CNT_W'(COLS);
          end else begin
            done_d     = 1'b1;
            out_row_d  = adv_row;
            out_col_d  = adv_col;
            out_cell_d = '0;
          end
        end
      end
      ST_BS_STEP: begin
        pos_d   = pos_q - ADDR_W'(1);
        mem_we  = 1'b1;
        mem_wa  = pos_q - ADDR_W'(1);
        rd_addr = (pos_q >= ADDR_W'(2)) ? pos_q - ADDR_W'(2) : '0;
        if (col_q == '0) begin
          col_d = COL_W'(COLS - 1);
          row_d = row_q - ROW_W'(1);
        end else begin
          col_d = col_q - COL_W'(1);
        end
      end
      ST_BS_CHECK: begin
        if (!(pos_q != '0 && rd_blank)) begin
          done_d     = 1'b1;
          out_row_d  = row_q;
          out_col_d  = col_q;
          out_cell_d = '0;
        end
      end
      ST_SCROLL_COPY: begin
        rd_addr = (cnt_q < CNT_W'(NCELLS)) ? cnt_q[ADDR_W-1:0] : '0;
        mem_we  = cnt_q > CNT_W'(COLS);
        mem_wa  = ADDR_W'(cnt_q - CNT_W'(COLS + 1));
        mem_wd  = rdata_q;
        cnt_d   = (cnt_q == CNT_W'(NCELLS)) ? CNT_W'(NCELLS - COLS) : cnt_q + CNT_W'(1);
      end
      ST_SCROLL_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[ADDR_W-1:0];
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NCELLS - 1)) begin
          done_d     = 1'b1;
          out_row_d  = row_q;
          out_col_d  = col_q;
          out_cell_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      row_q    <= '0;
      col_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      tab_n_q  <= '0;
      rd_oor_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      tab_n_q  <= tab_n_d;
      rd_oor_q <= rd_oor_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_cell_q <= out_cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_addr];
  end

  assign done_o       = done_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_char_o  = out_cell_q;

  `TCCE_ASSERT(a_cursor_range, (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLS)), "cursor out of range")
  `TCCE_ASSERT(a_pos_match, pos_q == ADDR_W'(row_q * COLS + col_q), "linear cursor out of step")
  `TCCE_ASSERT_NEXT(a_read_issue, (state_q == ST_IDLE) && start && (action_i == ACT_READ), state_q == ST_READ, "read transfer not sequenced")
  `TCCE_ASSERT_NEXT(a_read_done, state_q == ST_READ, done_o && (state_q == ST_IDLE), "read result missing")

endmodule
